@@ rtl/core/tod_pkg.sv @@
`default_nettype none

package tod_pkg;

  // Field and register widths.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ROT_W           = 2;
  localparam int THR_W           = 15;
  localparam int DEB_W           = 4;
  localparam int THR_SQ_W        = 2 * THR_W;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = THR_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_LIMIT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT = 1'b1;

  // Register reset values.
  localparam logic [THR_W-1:0]    FLAT_LIMIT_RST     = THR_W'(7373);
  localparam logic [THR_SQ_W-1:0] FLAT_THR_SQ_RST    =
    THR_SQ_W'(FLAT_LIMIT_RST) * THR_SQ_W'(FLAT_LIMIT_RST);
  localparam logic [DEB_W-1:0]    DEBOUNCE_COUNT_RST = DEB_W'(5);
  localparam logic [DEB_W-1:0]    STABLE_COUNT_MAX   = {DEB_W{1'b1}};

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FORCE  = 1'b1;

  // Rotation codes.
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // Queue between the classifier and the debouncer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // A classified item: for a sample, rot is the quadrant and flat says the
  // in-plane gravity was too weak; for a force item, rot is the forced value.
  typedef struct packed {
    logic             kind;
    logic             flat;
    logic [ROT_W-1:0] rot;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/tod_front.sv @@
`default_nettype none

module tod_front #(
  parameter int SAMPLE_BITS = tod_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          thr_write,
  input  wire logic [tod_pkg::THR_W-1:0]     thr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
  input  wire logic [tod_pkg::ROT_W-1:0]     forced_rotation,
  output logic                               push,
  input  wire logic                          queue_full,
  output tod_pkg::item_t                     push_item
);
  import tod_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int MAG_W = SQ_W + 1;
  localparam int CMP_W = (MAG_W > THR_SQ_W) ? MAG_W : THR_SQ_W;

  logic [THR_SQ_W-1:0] thr_sq;

  logic             s1_valid;
  logic             s1_kind;
  logic [ROT_W-1:0] s1_rot;
  logic [SQ_W-1:0]  s1_xsq;
  logic [SQ_W-1:0]  s1_ysq;

  logic signed [SQ_W-1:0]        xsq;
  logic signed [SQ_W-1:0]        ysq;
  logic signed [SAMPLE_BITS:0]   xe;
  logic signed [SAMPLE_BITS:0]   ye;
  logic signed [SAMPLE_BITS:0]   neg_y;
  logic [ROT_W-1:0]              quad;
  logic [MAG_W-1:0]              mag;
  logic                          take;

  // The squared threshold is kept ready so the sample path needs no multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq <= FLAT_THR_SQ_RST;
    end else if (thr_write) begin
      thr_sq <= THR_SQ_W'(thr_data) * THR_SQ_W'(thr_data);
    end
  end

  // Quadrant of the gravity vector by exact comparisons, one bit wider so
  // that negating the most negative sample does not overflow.
  always_comb begin
    xe    = {accel_x[SAMPLE_BITS-1], accel_x};
    ye    = {accel_y[SAMPLE_BITS-1], accel_y};
    neg_y = -ye;
    if (xe == '0 && ye == '0) begin
      quad = ROT_0;
    end else if (ye > 0 && xe >= neg_y && xe < ye) begin
      quad = ROT_0;
    end else if (xe > 0 && xe >= ye && xe > neg_y) begin
      quad = ROT_90;
    end else if (ye < 0 && xe <= neg_y && xe > ye) begin
      quad = ROT_180;
    end else begin
      quad = ROT_270;
    end
  end

  assign xsq = SQ_W'(accel_x) * SQ_W'(accel_x);
  assign ysq = SQ_W'(accel_y) * SQ_W'(accel_y);

  assign in_ready = !s1_valid || !queue_full;
  assign take     = in_valid && in_ready;
  assign push     = s1_valid && !queue_full;

  // Stage one: squares and quadrant (or forced rotation) registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind <= kind;
      s1_rot  <= (kind == KIND_FORCE) ? forced_rotation : quad;
      s1_xsq  <= $unsigned(xsq);
      s1_ysq  <= $unsigned(ysq);
    end
  end

  // Magnitude compare against the squared threshold at the queue input.
  assign mag = {1'b0, s1_xsq} + {1'b0, s1_ysq};

  always_comb begin
    push_item.kind = s1_kind;
    push_item.rot  = s1_rot;
    push_item.flat = CMP_W'(mag) < CMP_W'(thr_sq);
  end

endmodule

`default_nettype wire

@@ rtl/core/tod_queue.sv @@
`default_nettype none

module tod_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tod_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output tod_pkg::item_t      pop_item
);
  import tod_pkg::*;

  item_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_item  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tod_back.sv @@
`default_nettype none

module tod_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      deb_write,
  input  wire logic [tod_pkg::DEB_W-1:0] deb_data,
  input  wire logic                      item_valid,
  input  wire tod_pkg::item_t            item,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [tod_pkg::ROT_W-1:0]      rotation
);
  import tod_pkg::*;

  logic [DEB_W-1:0] debounce_count;
  logic [ROT_W-1:0] current_rotation;
  logic [ROT_W-1:0] pending_rotation;
  logic [DEB_W-1:0] stable_count;

  logic [ROT_W-1:0] current_next;
  logic [ROT_W-1:0] pending_next;
  logic [DEB_W-1:0] stable_next;
  logic [DEB_W-1:0] count_inc;
  logic [ROT_W-1:0] cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= DEBOUNCE_COUNT_RST;
    end else if (deb_write) begin
      debounce_count <= deb_data;
    end
  end

  // Take an item whenever the output register is free or being drained.
  assign pop = item_valid && (!out_valid || out_ready);

  // Debounce update for one classified item.
  always_comb begin
    current_next = current_rotation;
    pending_next = pending_rotation;
    stable_next  = stable_count;
    cand         = item.flat ? current_rotation : item.rot;
    count_inc    = (stable_count < STABLE_COUNT_MAX) ? stable_count + 1'b1 : stable_count;
    if (item.kind == KIND_FORCE) begin
      current_next = item.rot;
      pending_next = item.rot;
      stable_next  = '0;
    end else if (cand == current_rotation) begin
      stable_next = '0;
    end else if (cand != pending_rotation) begin
      pending_next = cand;
      stable_next  = '0;
    end else if (count_inc >= debounce_count) begin
      current_next = cand;
      stable_next  = '0;
    end else begin
      stable_next = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_rotation <= ROT_0;
      pending_rotation <= ROT_0;
      stable_count     <= '0;
    end else if (pop) begin
      current_rotation <= current_next;
      pending_rotation <= pending_next;
      stable_count     <= stable_next;
    end
  end

  // Output register holds the result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rotation <= current_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tilt_orientation_debouncer.sv @@
`default_nettype none

// Screen rotation from accelerometer x and y samples. Every transfer in
// produces exactly one rotation result (0..3 for 0, 90, 180, 270 degrees).
// A sample whose in-plane magnitude is below the flat limit (register 0)
// keeps the current rotation; otherwise its quadrant must repeat until a
// count reaches the debounce count (register 1) before the rotation changes.
// A force item (kind 1) sets the rotation at once. The block takes one item
// per cycle while the squaring stage is empty or the queue is not full, since
// the squaring stage and the debouncer each take a new item as soon as their
// last one moves on. A result passes through the squaring stage register, the
// two-entry queue and the output register in that order. While results are
// held back, four items (squaring stage, queue and output register) sit in
// the block before the input stalls. Write the registers only while no item
// is in flight.
module tilt_orientation_debouncer #(
  parameter int SAMPLE_BITS = tod_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [tod_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tod_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             kind,
  input  wire logic signed [SAMPLE_BITS-1:0]    accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0]    accel_y,
  input  wire logic [tod_pkg::ROT_W-1:0]        forced_rotation,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tod_pkg::ROT_W-1:0]             rotation
);
  import tod_pkg::*;

  logic  thr_write;
  logic  deb_write;
  logic  push;
  logic  queue_full;
  item_t push_item;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  assign thr_write = cfg_write && (cfg_index == REG_FLAT_LIMIT);
  assign deb_write = cfg_write && (cfg_index == REG_DEBOUNCE_COUNT);

  tod_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .thr_write       (thr_write),
    .thr_data        (cfg_data[THR_W-1:0]),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .forced_rotation (forced_rotation),
    .push            (push),
    .queue_full      (queue_full),
    .push_item       (push_item)
  );

  tod_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  tod_back u_back (
    .clk        (clk),
    .rst        (rst),
    .deb_write  (deb_write),
    .deb_data   (cfg_data[DEB_W-1:0]),
    .item_valid (pop_valid),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rotation   (rotation)
  );

endmodule

`default_nettype wire
